/* sv/kmc_pkg.sv */
// kmc_pkg: shared types and constants of the 2-D k-means clustering block.
// No dependencies; imported by every module of the block.
package kmc_pkg;

  // Configuration port layout
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam int CLUSTER_CFG_W = 5;
  localparam int ROUND_CFG_W = 8;
  localparam logic CFG_SEL_NUM_CLUST = 1'b0;      // byte address 0
  localparam logic CFG_SEL_ROUND_COUNT = 1'b1;    // byte address 4
  localparam logic [CLUSTER_CFG_W-1:0] NUM_CLUST_RST = 5'd4;
  localparam logic [ROUND_CFG_W-1:0] ROUND_COUNT_RST = 8'd10;

  // Top-level sequencer
  typedef enum logic [5:0] {
    ST_LOAD   = 6'b000001,
    ST_SEED   = 6'b000010,
    ST_ASSIGN = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_RECOMP = 6'b010000,
    ST_EMIT   = 6'b100000
  } kmc_state_t;

  // Centroid update sub-steps
  typedef enum logic [2:0] {
    PH_CHK = 3'b001,
    PH_WY  = 3'b010,
    PH_WX  = 3'b100
  } kmc_phase_t;

  // Broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic clear;    // zero sums and member counts
    logic cen_we;   // centroid write, addressed by cell index
    logic acc_vld;  // accumulate a labeled point, addressed by cell index
  } cell_ctl_t;

endpackage

/* sv/kmc_cell.sv */
// kmc_cell: one cluster cell of the distance chain; holds a centroid, its sums and count.
// Depends on kmc_pkg.
module kmc_cell import kmc_pkg::*; #(
  parameter int CELL_IDX = 0,
  parameter int COORD_BITS = 24,
  parameter int IW = 4,
  parameter int SUM_W = 35,
  parameter int CNT_W = 11,
  parameter int D_W = 51
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  cell_ctl_t                    ctl,
  input  logic                         active,
  input  logic [IW-1:0]                cen_idx,
  input  logic signed [COORD_BITS-1:0] cen_y_in,
  input  logic signed [COORD_BITS-1:0] cen_x_in,
  input  logic [IW-1:0]                acc_idx,
  input  logic signed [COORD_BITS-1:0] acc_y,
  input  logic signed [COORD_BITS-1:0] acc_x,
  input  logic                         i_vld,
  input  logic signed [COORD_BITS-1:0] i_y,
  input  logic signed [COORD_BITS-1:0] i_x,
  input  logic                         i_bvld,
  input  logic [D_W-1:0]               i_bd,
  input  logic [IW-1:0]                i_bidx,
  output logic                         o_vld,
  output logic signed [COORD_BITS-1:0] o_y,
  output logic signed [COORD_BITS-1:0] o_x,
  output logic                         o_bvld,
  output logic [D_W-1:0]               o_bd,
  output logic [IW-1:0]                o_bidx,
  output logic signed [COORD_BITS-1:0] cen_y,
  output logic signed [COORD_BITS-1:0] cen_x,
  output logic signed [SUM_W-1:0]      sum_y,
  output logic signed [SUM_W-1:0]      sum_x,
  output logic [CNT_W-1:0]             size
);

  localparam logic [IW-1:0] MY_IDX = IW'(CELL_IDX);

  logic signed [COORD_BITS-1:0] cen_y_r, cen_x_r;
  logic signed [SUM_W-1:0]      sum_y_r, sum_x_r;
  logic [CNT_W-1:0]             size_r;

  // stage 1: coordinate distance
  logic                         s1_vld_r, s1_bvld_r;
  logic signed [COORD_BITS-1:0] s1_y_r, s1_x_r;
  logic [D_W-1:0]               s1_bd_r;
  logic [IW-1:0]                s1_bidx_r;
  logic [COORD_BITS:0]          dy_r, dx_r;
  // stage 2: squares
  logic                         s2_vld_r, s2_bvld_r;
  logic signed [COORD_BITS-1:0] s2_y_r, s2_x_r;
  logic [D_W-1:0]               s2_bd_r;
  logic [IW-1:0]                s2_bidx_r;
  logic [2*COORD_BITS+1:0]      sqy_r, sqx_r;
  // stage 3: compare, hand to neighbor
  logic                         o_vld_r, o_bvld_r;
  logic signed [COORD_BITS-1:0] o_y_r, o_x_r;
  logic [D_W-1:0]               o_bd_r;
  logic [IW-1:0]                o_bidx_r;

  logic signed [COORD_BITS:0] diff_y, diff_x;
  logic [D_W-1:0]             dsq;
  logic                       take;

  assign diff_y = {cen_y_r[COORD_BITS-1], cen_y_r} - {i_y[COORD_BITS-1], i_y};
  assign diff_x = {cen_x_r[COORD_BITS-1], cen_x_r} - {i_x[COORD_BITS-1], i_x};
  assign dsq = D_W'(sqy_r) + D_W'(sqx_r);
  // strict compare keeps the lower index on a tie
  assign take = active && (!s2_bvld_r || (dsq < s2_bd_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      o_vld_r  <= 1'b0;
      size_r   <= '0;
      sum_y_r  <= '0;
      sum_x_r  <= '0;
    end else begin
      s1_vld_r <= i_vld;
      s2_vld_r <= s1_vld_r;
      o_vld_r  <= s2_vld_r;
      if (ctl.clear) begin
        size_r  <= '0;
        sum_y_r <= '0;
        sum_x_r <= '0;
      end else if (ctl.acc_vld && (acc_idx == MY_IDX)) begin
        size_r  <= size_r + CNT_W'(1);
        sum_y_r <= sum_y_r + {{(SUM_W-COORD_BITS){acc_y[COORD_BITS-1]}}, acc_y};
        sum_x_r <= sum_x_r + {{(SUM_W-COORD_BITS){acc_x[COORD_BITS-1]}}, acc_x};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cen_we && (cen_idx == MY_IDX)) begin
      cen_y_r <= cen_y_in;
      cen_x_r <= cen_x_in;
    end
    s1_bvld_r <= i_bvld;
    s1_y_r    <= i_y;
    s1_x_r    <= i_x;
    s1_bd_r   <= i_bd;
    s1_bidx_r <= i_bidx;
    dy_r      <= diff_y[COORD_BITS] ? $unsigned(-diff_y) : $unsigned(diff_y);
    dx_r      <= diff_x[COORD_BITS] ? $unsigned(-diff_x) : $unsigned(diff_x);
    s2_bvld_r <= s1_bvld_r;
    s2_y_r    <= s1_y_r;
    s2_x_r    <= s1_x_r;
    s2_bd_r   <= s1_bd_r;
    s2_bidx_r <= s1_bidx_r;
    sqy_r     <= dy_r * dy_r;
    sqx_r     <= dx_r * dx_r;
    o_y_r     <= s2_y_r;
    o_x_r     <= s2_x_r;
    o_bvld_r  <= s2_bvld_r || take;
    o_bd_r    <= take ? dsq : s2_bd_r;
    o_bidx_r  <= take ? MY_IDX : s2_bidx_r;
  end

  assign o_vld  = o_vld_r;
  assign o_y    = o_y_r;
  assign o_x    = o_x_r;
  assign o_bvld = o_bvld_r;
  assign o_bd   = o_bd_r;
  assign o_bidx = o_bidx_r;
  assign cen_y  = cen_y_r;
  assign cen_x  = cen_x_r;
  assign sum_y  = sum_y_r;
  assign sum_x  = sum_x_r;
  assign size   = size_r;

endmodule

/* sv/kmc_div.sv */
// kmc_div: shared restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on kmc_pkg.
module kmc_div import kmc_pkg::*; #(
  parameter int NUM_W = 35,
  parameter int DEN_W = 11,
  parameter int Q_W = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [NUM_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    busy,
  output logic                    done,
  output logic signed [Q_W-1:0]   quo
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_r, done_r, neg_r;
  logic [CW-1:0]    cnt_r;
  logic [NUM_W-1:0] num_r;
  logic [DEN_W-1:0] rem_r, den_r;
  logic [DEN_W:0]   trial;
  logic             ge;

  assign trial = {rem_r, num_r[NUM_W-1]};
  assign ge = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == CW'(NUM_W - 1))) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[NUM_W-1];
      num_r <= num[NUM_W-1] ? $unsigned(-num) : $unsigned(num);
      den_r <= den;
      rem_r <= '0;
      cnt_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? DEN_W'(trial - {1'b0, den_r}) : DEN_W'(trial);
      num_r <= {num_r[NUM_W-2:0], ge};
      cnt_r <= cnt_r + CW'(1);
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = neg_r ? -Q_W'(num_r) : Q_W'(num_r);

endmodule

/* sv/kmeans_2d_clustering_top.sv */
// kmeans_2d_clustering_top: top level of the 2-D k-means clustering block.
// Depends on kmc_pkg, kmc_cell and kmc_div.
//
// Points load one item per cycle into the point memory until an item with
// in_tlast arrives; the block then accepts no item until the last cluster
// result has been taken. The first points of the set, one per configured
// cluster, seed the centroids (missing seeds start at the origin). Each
// assignment pass streams every stored point through a chain of MAX_CLUSTERS
// cells, one point per cycle; each cell registers the coordinate distances,
// their squares and the compare result. Each refinement round first updates
// the centroids of the non-empty clusters through one shared bit-serial
// divider, then runs a pass. After the last round one result per cluster
// comes out in index order, the last one with out_tlast. Points beyond
// MAX_POINTS are dropped and flagged in every result of the set. Registers:
// the cluster number at byte address 0, round_count at byte address 4; write
// them only while the block is idle.
module kmeans_2d_clustering_top import kmc_pkg::*; #(
  parameter int MAX_POINTS = 1024,
  parameter int MAX_CLUSTERS = 16,
  parameter int COORD_BITS = 24,
  localparam int IW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1,
  localparam int CNT_W = $clog2(MAX_POINTS + 1),
  localparam int IN_TW = ((2 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = IW + 2 * COORD_BITS + CNT_W + 1,
  localparam int OUT_TW = ((OUT_W + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TW-1:0]      in_tdata,   // point_y, point_x
  input  logic                  in_tlast,   // last_point
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_TW-1:0]     out_tdata,  // cluster_index, centroid_y, centroid_x,
                                            // member_count, points_dropped
  output logic                  out_tlast,  // last_result
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  localparam int KW = $clog2(MAX_CLUSTERS + 1);
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int SUM_W = COORD_BITS + CNT_W;
  localparam int D_W = 2 * COORD_BITS + 3;
  localparam int PW = 2 * COORD_BITS;
  localparam int DRAIN_N = 3 * MAX_CLUSTERS + 3;
  localparam int DW = $clog2(DRAIN_N + 1);

  // ---------------------------------------------------------------- config
  logic [CLUSTER_CFG_W-1:0] cluster_cnt_r;
  logic [ROUND_CFG_W-1:0]   round_cnt_r;
  logic                     cfg_wr;
  logic [KW-1:0]            k_cfg;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cluster_cnt_r <= NUM_CLUST_RST;
      round_cnt_r   <= ROUND_COUNT_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        CFG_SEL_NUM_CLUST:   cluster_cnt_r <= cfg_pwdata[CLUSTER_CFG_W-1:0];
        CFG_SEL_ROUND_COUNT: round_cnt_r   <= cfg_pwdata[ROUND_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      CFG_SEL_NUM_CLUST:   cfg_prdata = CFG_DATA_W'(cluster_cnt_r);
      CFG_SEL_ROUND_COUNT: cfg_prdata = CFG_DATA_W'(round_cnt_r);
      default:             cfg_prdata = '0;
    endcase
  end

  // clamp the cluster count into 1..MAX_CLUSTERS
  always_comb begin
    if (cluster_cnt_r == '0) begin
      k_cfg = KW'(1);
    end else if (int'(cluster_cnt_r) > MAX_CLUSTERS) begin
      k_cfg = KW'(MAX_CLUSTERS);
    end else begin
      k_cfg = KW'(cluster_cnt_r);
    end
  end

  // ------------------------------------------------------------- sequencer
  kmc_state_t state_r, state_nxt;
  kmc_phase_t ph_r, ph_nxt;

  logic [CNT_W-1:0]       n_r, n_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [KW-1:0]          k_r, k_nxt;
  logic [ROUND_CFG_W-1:0] rounds_r, rounds_nxt;
  logic [KW-1:0]          seed_cnt_r, seed_cnt_nxt;
  logic [CNT_W-1:0]       asg_cnt_r, asg_cnt_nxt;
  logic [DW-1:0]          drain_cnt_r, drain_cnt_nxt;
  logic [KW-1:0]          rc_idx_r, rc_idx_nxt;
  logic [KW-1:0]          em_idx_r, em_idx_nxt;

  logic in_acc, out_acc, wr_en;
  logic seed_go, feed_go, rc_wr, div_start, em_load;

  logic [PW-1:0] pt_mem [MAX_POINTS];
  logic [AW-1:0] rd_addr;
  logic [PW-1:0] rd_data_r;

  logic                         seed_vld_r, seed_zero_r;
  logic [IW-1:0]                seed_idx_r;
  logic                         feed_vld_r;
  logic signed [COORD_BITS-1:0] qy_r;

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;
  assign wr_en = in_acc && (n_r < CNT_W'(MAX_POINTS));

  // per-cell views
  logic signed [COORD_BITS-1:0] c_cen_y [MAX_CLUSTERS];
  logic signed [COORD_BITS-1:0] c_cen_x [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]      c_sum_y [MAX_CLUSTERS];
  logic signed [SUM_W-1:0]      c_sum_x [MAX_CLUSTERS];
  logic [CNT_W-1:0]             c_size  [MAX_CLUSTERS];

  logic [IW-1:0]           rc_sel, em_sel;
  logic [CNT_W-1:0]        rc_size;
  logic                    div_busy, div_done;
  logic signed [SUM_W-1:0] div_num;
  logic signed [COORD_BITS-1:0] div_quo;

  assign rc_sel = IW'(rc_idx_r);
  assign em_sel = IW'(em_idx_r);
  assign rc_size = c_size[rc_sel];
  assign div_num = (ph_r == PH_WY) ? c_sum_x[rc_sel] : c_sum_y[rc_sel];
  assign em_load = (state_r == ST_EMIT) && (!out_tvalid || out_tready) && (em_idx_r != k_r);

  always_comb begin
    state_nxt     = state_r;
    ph_nxt        = ph_r;
    n_nxt         = n_r;
    ovf_nxt       = ovf_r;
    k_nxt         = k_r;
    rounds_nxt    = rounds_r;
    seed_cnt_nxt  = seed_cnt_r;
    asg_cnt_nxt   = asg_cnt_r;
    drain_cnt_nxt = drain_cnt_r;
    rc_idx_nxt    = rc_idx_r;
    em_idx_nxt    = em_idx_r;
    seed_go       = 1'b0;
    feed_go       = 1'b0;
    rc_wr         = 1'b0;
    div_start     = 1'b0;
    rd_addr       = AW'(asg_cnt_r);
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (wr_en) begin
            n_nxt = n_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            k_nxt        = k_cfg;
            rounds_nxt   = round_cnt_r;
            seed_cnt_nxt = '0;
            state_nxt    = ST_SEED;
          end
        end
      end
      ST_SEED: begin
        rd_addr = AW'(seed_cnt_r);
        if (seed_cnt_r == k_r) begin
          asg_cnt_nxt = '0;
          state_nxt   = ST_ASSIGN;
        end else begin
          seed_go      = 1'b1;
          seed_cnt_nxt = seed_cnt_r + KW'(1);
        end
      end
      ST_ASSIGN: begin
        feed_go     = 1'b1;
        asg_cnt_nxt = asg_cnt_r + CNT_W'(1);
        if (asg_cnt_nxt == n_r) begin
          drain_cnt_nxt = '0;
          state_nxt     = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        drain_cnt_nxt = drain_cnt_r + DW'(1);
        if (drain_cnt_r == DW'(DRAIN_N - 1)) begin
          if (rounds_r == '0) begin
            em_idx_nxt = '0;
            state_nxt  = ST_EMIT;
          end else begin
            rounds_nxt = rounds_r - ROUND_CFG_W'(1);
            rc_idx_nxt = '0;
            ph_nxt     = PH_CHK;
            state_nxt  = ST_RECOMP;
          end
        end
      end
      ST_RECOMP: begin
        case (ph_r)
          PH_CHK: begin
            if (rc_idx_r == k_r) begin
              asg_cnt_nxt = '0;
              state_nxt   = ST_ASSIGN;
            end else if (rc_size == '0) begin
              // empty cluster: keep its centroid
              rc_idx_nxt = rc_idx_r + KW'(1);
            end else begin
              div_start = 1'b1;
              ph_nxt    = PH_WY;
            end
          end
          PH_WY: begin
            if (div_done) begin
              div_start = 1'b1;
              ph_nxt    = PH_WX;
            end
          end
          PH_WX: begin
            if (div_done) begin
              rc_wr      = 1'b1;
              rc_idx_nxt = rc_idx_r + KW'(1);
              ph_nxt     = PH_CHK;
            end
          end
          default: ph_nxt = PH_CHK;
        endcase
      end
      ST_EMIT: begin
        if (em_load) begin
          em_idx_nxt = em_idx_r + KW'(1);
        end
        if (out_acc && out_tlast) begin
          n_nxt     = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      ph_r       <= PH_CHK;
      n_r        <= '0;
      ovf_r      <= 1'b0;
      k_r        <= KW'(1);
      rounds_r   <= '0;
      seed_cnt_r <= '0;
      asg_cnt_r  <= '0;
      drain_cnt_r <= '0;
      rc_idx_r   <= '0;
      em_idx_r   <= '0;
      seed_vld_r <= 1'b0;
      feed_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      ph_r       <= ph_nxt;
      n_r        <= n_nxt;
      ovf_r      <= ovf_nxt;
      k_r        <= k_nxt;
      rounds_r   <= rounds_nxt;
      seed_cnt_r <= seed_cnt_nxt;
      asg_cnt_r  <= asg_cnt_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      rc_idx_r   <= rc_idx_nxt;
      em_idx_r   <= em_idx_nxt;
      seed_vld_r <= seed_go;
      feed_vld_r <= feed_go;
    end
  end

  // point memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      pt_mem[AW'(n_r)] <= in_tdata[PW-1:0];
    end
    rd_data_r <= pt_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    seed_idx_r  <= IW'(seed_cnt_r);
    seed_zero_r <= int'(seed_cnt_r) >= int'(n_r);
    if (div_done && (ph_r == PH_WY)) begin
      qy_r <= div_quo;
    end
  end

  kmc_div #(
    .NUM_W(SUM_W),
    .DEN_W(CNT_W),
    .Q_W  (COORD_BITS)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(div_start),
    .num  (div_num),
    .den  (rc_size),
    .busy (div_busy),
    .done (div_done),
    .quo  (div_quo)
  );

  // ---------------------------------------------------------- cell chain
  cell_ctl_t                    ctl;
  logic [IW-1:0]                cen_idx;
  logic signed [COORD_BITS-1:0] cen_y_w, cen_x_w;

  logic                         l_vld  [MAX_CLUSTERS+1];
  logic signed [COORD_BITS-1:0] l_y    [MAX_CLUSTERS+1];
  logic signed [COORD_BITS-1:0] l_x    [MAX_CLUSTERS+1];
  logic                         l_bvld [MAX_CLUSTERS+1];
  logic [D_W-1:0]               l_bd   [MAX_CLUSTERS+1];
  logic [IW-1:0]                l_bidx [MAX_CLUSTERS+1];

  // seeding and centroid updates never overlap
  always_comb begin
    if (seed_vld_r) begin
      cen_idx = seed_idx_r;
      cen_y_w = seed_zero_r ? '0 : rd_data_r[COORD_BITS-1:0];
      cen_x_w = seed_zero_r ? '0 : rd_data_r[PW-1:COORD_BITS];
    end else begin
      cen_idx = rc_sel;
      cen_y_w = qy_r;
      cen_x_w = div_quo;
    end
  end

  assign ctl.clear   = (state_r == ST_ASSIGN) && (asg_cnt_r == '0);
  assign ctl.cen_we  = seed_vld_r || rc_wr;
  assign ctl.acc_vld = l_vld[MAX_CLUSTERS];

  // chain head: a fresh point with no best yet
  assign l_vld[0]  = feed_vld_r;
  assign l_y[0]    = rd_data_r[COORD_BITS-1:0];
  assign l_x[0]    = rd_data_r[PW-1:COORD_BITS];
  assign l_bvld[0] = 1'b0;
  assign l_bd[0]   = '0;
  assign l_bidx[0] = '0;

  for (genvar g = 0; g < MAX_CLUSTERS; g++) begin : g_cell
    kmc_cell #(
      .CELL_IDX  (g),
      .COORD_BITS(COORD_BITS),
      .IW        (IW),
      .SUM_W     (SUM_W),
      .CNT_W     (CNT_W),
      .D_W       (D_W)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .active  (int'(k_r) > g),
      .cen_idx (cen_idx),
      .cen_y_in(cen_y_w),
      .cen_x_in(cen_x_w),
      .acc_idx (l_bidx[MAX_CLUSTERS]),
      .acc_y   (l_y[MAX_CLUSTERS]),
      .acc_x   (l_x[MAX_CLUSTERS]),
      .i_vld   (l_vld[g]),
      .i_y     (l_y[g]),
      .i_x     (l_x[g]),
      .i_bvld  (l_bvld[g]),
      .i_bd    (l_bd[g]),
      .i_bidx  (l_bidx[g]),
      .o_vld   (l_vld[g+1]),
      .o_y     (l_y[g+1]),
      .o_x     (l_x[g+1]),
      .o_bvld  (l_bvld[g+1]),
      .o_bd    (l_bd[g+1]),
      .o_bidx  (l_bidx[g+1]),
      .cen_y   (c_cen_y[g]),
      .cen_x   (c_cen_x[g]),
      .sum_y   (c_sum_y[g]),
      .sum_x   (c_sum_x[g]),
      .size    (c_size[g])
    );
  end

  // ---------------------------------------------------------- result port
  logic             out_vld_r;
  logic [OUT_W-1:0] out_data_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (em_load) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (em_load) begin
      out_data_r <= {ovf_r, c_size[em_sel], c_cen_x[em_sel], c_cen_y[em_sel], em_sel};
      out_last_r <= (em_idx_r + KW'(1)) == k_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = OUT_TW'(out_data_r);
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_out_only_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (state_r == ST_EMIT))
    else $error("result valid outside the emit phase");
  a_acc_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.acc_vld |-> ((state_r == ST_ASSIGN) || (state_r == ST_DRAIN)))
    else $error("point accumulated outside an assignment pass");
  a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider started while busy");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(n_r) <= MAX_POINTS)
    else $error("point count beyond capacity");
`endif

endmodule

/* tb/tb.sv */
// tb: self-checking testbench for kmeans_2d_clustering_top.
// Depends on kmc_pkg and the block's RTL. It predicts the cluster results of
// each point set in SystemVerilog and compares every result field by field.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import kmc_pkg::*;

  localparam int NPTS = 1024;
  localparam int NCL = 16;
  localparam int CW = 24;
  // Register indexes; each register sits at byte address 4*index
  localparam int REG_NUM_CLUST = 0;
  localparam int REG_ROUND_COUNT = 1;

  typedef struct {
    logic [3:0]    idx;
    logic [CW-1:0] cy;
    logic [CW-1:0] cx;
    logic [10:0]   members;
    logic          dropped;
    logic          last;
  } cluster_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [47:0] in_tdata = '0;      // point_y [23:0], point_x [47:24]
  logic in_tlast = 1'b0;           // last_point
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [63:0] out_tdata;          // cluster_index [3:0], centroid_y [27:4],
                                   // centroid_x [51:28], member_count [62:52],
                                   // points_dropped [63]
  logic out_tlast;                 // last_result
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic cfg_pready;

  kmeans_2d_clustering_top uut (.*);

  always #1 clk = ~clk;

  // Shadow of the block: configuration, the current point set, centroids
  int unsigned cl_cfg = 4;
  int unsigned rounds_cfg = 10;
  longint set_y[$];
  longint set_x[$];
  bit set_dropped;
  longint cen_y[NCL], cen_x[NCL], acc_y[NCL], acc_x[NCL];
  int unsigned members[NCL];
  cluster_res_t cluster_q[$];
  int mismatches = 0;
  int burst_left = 0;

  // Assign every stored point to its nearest centroid; lowest index wins ties
  function automatic void regroup(int unsigned k);
    longint unsigned d, bd, dy, dx;
    int unsigned best;
    for (int c = 0; c < NCL; c++) begin
      acc_y[c] = 0; acc_x[c] = 0; members[c] = 0;
    end
    for (int p = 0; p < set_y.size(); p++) begin
      best = 0;
      bd = 0;
      for (int c = 0; c < k; c++) begin
        dy = (cen_y[c] >= set_y[p]) ? cen_y[c] - set_y[p] : set_y[p] - cen_y[c];
        dx = (cen_x[c] >= set_x[p]) ? cen_x[c] - set_x[p] : set_x[p] - cen_x[c];
        d = dy * dy + dx * dx;
        if (c == 0 || d < bd) begin
          bd = d;
          best = c;
        end
      end
      acc_y[best] += set_y[p];
      acc_x[best] += set_x[p];
      members[best]++;
    end
  endfunction

  // Run the whole clustering for the finished set and queue its results
  function automatic void cluster_set();
    int unsigned k;
    cluster_res_t r;
    k = (cl_cfg < 1) ? 1 : (cl_cfg > NCL) ? NCL : cl_cfg;
    for (int c = 0; c < k; c++) begin
      cen_y[c] = (c < set_y.size()) ? set_y[c] : 0;
      cen_x[c] = (c < set_x.size()) ? set_x[c] : 0;
    end
    regroup(k);
    for (int rnd = 0; rnd < rounds_cfg; rnd++) begin
      for (int c = 0; c < k; c++)
        if (members[c] != 0) begin
          cen_y[c] = acc_y[c] / longint'(members[c]);
          cen_x[c] = acc_x[c] / longint'(members[c]);
        end
      regroup(k);
    end
    for (int c = 0; c < k; c++) begin
      r.idx = 4'(c);
      r.cy = cen_y[c][CW-1:0];
      r.cx = cen_x[c][CW-1:0];
      r.members = 11'(members[c]);
      r.dropped = set_dropped;
      r.last = (c + 1 == k);
      cluster_q.insert(cluster_q.size(), r);
    end
    set_y.delete();
    set_x.delete();
    set_dropped = 1'b0;
  endfunction

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk);
      in_tvalid = 1'b0;
    end
  endtask

  // Offer one point and hold it until accepted, then update the shadow
  task automatic send_point(logic [CW-1:0] y, logic [CW-1:0] x, logic last);
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tdata = {x, y};
    in_tlast = last;
    do @(posedge clk); while (!in_tready);
    if (set_y.size() < NPTS) begin
      set_y.insert(set_y.size(), longint'(signed'(y)));
      set_x.insert(set_x.size(), longint'(signed'(x)));
    end else begin
      set_dropped = 1'b1;
    end
    if (last) cluster_set();
  endtask

  // Sender in bursts of random length, usually with a random gap between bursts
  task automatic send_bursty(logic [CW-1:0] y, logic [CW-1:0] x, logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 7));
    end
    burst_left--;
    send_point(y, x, last);
  endtask

  task automatic write_reg(int idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_pwrite = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr = CFG_ADDR_W'(idx * 4);
    cfg_pwdata = value;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    if (idx == REG_NUM_CLUST) cl_cfg = value[4:0];
    else if (idx == REG_ROUND_COUNT) rounds_cfg = value[7:0];
  endtask

  // Hold until every expected result has arrived, then let the block settle
  task automatic wait_drained();
    idle_cycles(1);
    while (cluster_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic configure(int unsigned k, int unsigned rounds);
    wait_drained();
    write_reg(REG_NUM_CLUST, k);
    write_reg(REG_ROUND_COUNT, rounds);
  endtask

  // Coordinates: full range, near a few hot spots, or at the extremes
  function automatic logic [CW-1:0] pick_coord(logic [CW-1:0] center);
    case ($urandom_range(0, 9))
      0, 1: return CW'($urandom);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return CW'(center + $urandom_range(0, 4095) - 2048);
    endcase
  endfunction

  // Receiver: ready pattern moves at random between always ready, mostly ready, mostly stalled and alternating runs
  int stall_mode = 0;
  int stall_tick = 0;
  always @(negedge clk) begin
    stall_tick++;
    if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_tready = 1'b1;
      1: out_tready = ($urandom_range(0, 3) != 0);
      2: out_tready = ($urandom_range(0, 3) == 0);
      default: out_tready = ((stall_tick / 8) % 2 == 0);
    endcase
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    cluster_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (cluster_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h last %b", out_tdata, out_tlast);
      end else begin
        e = cluster_q.pop_front();
        if (out_tdata[3:0] !== e.idx || out_tdata[27:4] !== e.cy ||
            out_tdata[51:28] !== e.cx || out_tdata[62:52] !== e.members ||
            out_tdata[63] !== e.dropped || out_tlast !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp idx %0d cy %h cx %h n %0d drop %b last %b; got %h last %b",
                     e.idx, e.cy, e.cx, e.members, e.dropped, e.last, out_tdata, out_tlast);
        end
      end
    end
  end

  // Extremes, ties, seedless clusters, clamped cluster counts, long runs
  task automatic test_directed();
    send_point(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_point(24'h800000, 24'h800000, 1'b0);
    send_point(24'h000000, 24'h000000, 1'b0);
    send_point(24'h800000, 24'h7FFFFF, 1'b0);
    send_point(24'h7FFFFF, 24'h800000, 1'b1);
    // one point for four clusters: three start at the origin and stay empty
    send_point(24'h001234, 24'hFFEDCC, 1'b1);
    // duplicate points tie between seeds; lowest index wins
    configure(3, 2);
    repeat (3) send_point(24'h000100, 24'h000100, 1'b0);
    send_point(24'hFFFF00, 24'h000100, 1'b1);
    configure(0, 0);   // zero clusters acts as one
    send_point(24'h000005, 24'hFFFFFB, 1'b0);
    send_point(24'hFFFFFD, 24'h000002, 1'b1);
    configure(31, 255);  // clamped to the maximum cluster count, most rounds
    for (int i = 0; i < 8; i++)
      send_point(CW'(i * 24'h011111), CW'(24'hF00000 + i * 37), i == 7);
    configure(17, 1);
    send_point(24'h000001, 24'hFFFFFF, 1'b1);
  endtask

  // Overfill the store: the dropped last point still closes the set
  task automatic test_overflow();
    configure(3, 1);
    for (int i = 0; i < NPTS + 6; i++)
      send_bursty(CW'($urandom), CW'($urandom), i == NPTS + 5);
    configure(2, 0);
    send_point(24'h000010, 24'h000020, 1'b0);
    send_point(24'hFFFFF0, 24'hFFFFE0, 1'b1);
  endtask

  task automatic test_random();
    int sent;
    int len;
    logic [CW-1:0] hot_y[4], hot_x[4];
    int h;
    sent = 0;
    while (sent < 430) begin
      if ($urandom_range(0, 7) == 0) configure($urandom_range(0, 31), $urandom_range(0, 12));
      else configure($urandom_range(1, 16), $urandom_range(0, 8));
      for (int j = 0; j < 4; j++) begin
        hot_y[j] = CW'($urandom);
        hot_x[j] = CW'($urandom);
      end
      len = $urandom_range(0, 5) == 0 ? $urandom_range(1, 4) : $urandom_range(5, 40);
      for (int i = 0; i < len; i++) begin
        h = $urandom_range(0, 3);
        send_bursty(pick_coord(hot_y[h]), pick_coord(hot_x[h]), i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_overflow();
    test_random();
    wait_drained();
    if (mismatches == 0 && cluster_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

/* kmeans_2d_clustering_top.f */
sv/kmc_pkg.sv
sv/kmc_cell.sv
sv/kmc_div.sv
sv/kmeans_2d_clustering_top.sv
tb/tb.sv
